// ----- rtl/ecp_pkg.sv -----
package ecp_pkg;

  localparam int DEF_FIELD_WIDTH = 64;
  localparam int CFG_IDX_W       = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_A = 1'b1;

  localparam logic [63:0] MODULUS_RST = 64'hFFFF_FFFF_FFFF_FFC5;
  localparam logic [63:0] CURVE_A_RST = 64'h0;

  typedef struct packed {
    logic               func;
    logic [63:0]        first_x;
    logic [63:0]        first_y;
    logic               first_is_infinity;
    logic [63:0]        second_x;
    logic [63:0]        second_y;
    logic               second_is_infinity;
    logic signed [63:0] scalar;
  } ecp_in_t;

  typedef struct packed {
    logic [63:0] result_x;
    logic [63:0] result_y;
    logic        result_is_infinity;
    logic        inverse_error;
  } ecp_out_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    go;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RED,
    ST_LOOP,
    ST_ADD,
    ST_X2,
    ST_N1,
    ST_N2,
    ST_N3,
    ST_DEN,
    ST_CN,
    ST_CD,
    ST_INV,
    ST_DIV,
    ST_QM,
    ST_NT,
    ST_LAM,
    ST_U1,
    ST_U2,
    ST_XR,
    ST_V1,
    ST_V2,
    ST_YR,
    ST_NEG,
    ST_OUT
  } st_t;

endpackage

// ----- rtl/ec_point_add_scalar_multiply.sv -----
// Elliptic-curve point unit for y^2 = x^3 + a*x + b over the integers
// modulo p, affine points with an infinity flag.
// Input beat: taken on a rising edge with start high and busy low. func 0
// adds the first and second point, func 1 multiplies the first point by the
// signed scalar (least significant bit first, double and add).
// Result beat: out_valid is high for exactly one cycle with out_data; the
// receiver cannot hold it off, and busy falls in the cycle after it.
// Configuration: cfg_we writes cfg_wdata to the modulus (index 0) or to the
// curve coefficient a (index 1); only write while busy is low.
// Every field operation runs on a single shared unit: add and subtract,
// a modular multiply and a division. Operand reduction takes five
// divisions. A doubling and a chord addition each also need an inverse,
// found by extended Euclid steps. A multiplication runs up to two point
// operations per scalar bit. With no usable modulus (below 2) the item
// goes straight to the result with the error flag set.
// Reset sets p to 2^64-59 and a to 0 and returns the sequencer to idle.
module ec_point_add_scalar_multiply import ecp_pkg::*; #(
  parameter int FIELD_WIDTH = DEF_FIELD_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  ecp_in_t              in_data,
  output logic                 out_valid,
  output ecp_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_wdata
);

  localparam int W = FIELD_WIDTH;
  localparam logic [2:0] RED_LAST = 3'd4;

  logic [63:0] modulus_r, curve_a_r;

  st_t         state_r, state_nxt;
  logic        wait_r, wait_nxt;
  logic [2:0]  red_cnt_r, red_cnt_nxt;
  logic        func_r, func_nxt, neg_r, neg_nxt, err_r, err_nxt, toc_r, toc_nxt;
  logic [63:0] k_r, k_nxt;
  logic [W-1:0] p_r, p_nxt, a_r, a_nxt;
  logic [W-1:0] rx_r, rx_nxt, ry_r, ry_nxt, cx_r, cx_nxt, cy_r, cy_nxt;
  logic         rinf_r, rinf_nxt, cinf_r, cinf_nxt;
  logic [W-1:0] num_r, num_nxt, den_r, den_nxt, lam_r, lam_nxt, tmp_r, tmp_nxt;
  logic [W-1:0] xr_r, xr_nxt, q_r, q_nxt;
  logic [W-1:0] r0_r, r0_nxt, r1_r, r1_nxt, t0_r, t0_nxt, t1_r, t1_nxt;

  // Operand S is the accumulator R, or the running point C when doubling it;
  // operand T is always C.
  logic [W-1:0] sx, sy;
  logic         sinf;

  alu_req_t     alu_req;
  logic         alu_use;
  alu_op_t      alu_op;
  logic [W-1:0] alu_a, alu_b, alu_res, alu_res2;
  logic         alu_done;

  logic         wb_en, wb_inf, do_post, inv_init;
  logic [W-1:0] wb_x, wb_y, inv_den;
  logic [63:0]  sc_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MODULUS_RST;
      curve_a_r <= CURVE_A_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODULUS: modulus_r <= cfg_wdata;
        CFG_CURVE_A: curve_a_r <= cfg_wdata;
        default:     modulus_r <= modulus_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wait_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wait_r  <= wait_nxt;
    end
  end

  always_ff @(posedge clk) begin
    red_cnt_r <= red_cnt_nxt;
    func_r    <= func_nxt;
    neg_r     <= neg_nxt;
    err_r     <= err_nxt;
    toc_r     <= toc_nxt;
    k_r       <= k_nxt;
    p_r       <= p_nxt;
    a_r       <= a_nxt;
    rx_r      <= rx_nxt;
    ry_r      <= ry_nxt;
    rinf_r    <= rinf_nxt;
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    cinf_r    <= cinf_nxt;
    num_r     <= num_nxt;
    den_r     <= den_nxt;
    lam_r     <= lam_nxt;
    tmp_r     <= tmp_nxt;
    xr_r      <= xr_nxt;
    q_r       <= q_nxt;
    r0_r      <= r0_nxt;
    r1_r      <= r1_nxt;
    t0_r      <= t0_nxt;
    t1_r      <= t1_nxt;
  end

  assign sx     = toc_r ? cx_r : rx_r;
  assign sy     = toc_r ? cy_r : ry_r;
  assign sinf   = toc_r ? cinf_r : rinf_r;
  assign sc_raw = in_data.scalar;

  always_comb begin
    state_nxt   = state_r;
    red_cnt_nxt = red_cnt_r;
    func_nxt    = func_r;
    neg_nxt     = neg_r;
    err_nxt     = err_r;
    toc_nxt     = toc_r;
    k_nxt       = k_r;
    p_nxt       = p_r;
    a_nxt       = a_r;
    rx_nxt      = rx_r;
    ry_nxt      = ry_r;
    rinf_nxt    = rinf_r;
    cx_nxt      = cx_r;
    cy_nxt      = cy_r;
    cinf_nxt    = cinf_r;
    num_nxt     = num_r;
    den_nxt     = den_r;
    lam_nxt     = lam_r;
    tmp_nxt     = tmp_r;
    xr_nxt      = xr_r;
    q_nxt       = q_r;
    r0_nxt      = r0_r;
    r1_nxt      = r1_r;
    t0_nxt      = t0_r;
    t1_nxt      = t1_r;
    alu_use     = 1'b0;
    alu_op      = ALU_ADD;
    alu_a       = '0;
    alu_b       = '0;
    wb_en       = 1'b0;
    wb_x        = '0;
    wb_y        = '0;
    wb_inf      = 1'b0;
    do_post     = 1'b0;
    inv_init    = 1'b0;
    inv_den     = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          p_nxt       = modulus_r[W-1:0];
          a_nxt       = curve_a_r[W-1:0];
          err_nxt     = 1'b0;
          func_nxt    = in_data.func;
          neg_nxt     = sc_raw[63];
          k_nxt       = sc_raw[63] ? (~sc_raw + 64'd1) : sc_raw;
          red_cnt_nxt = '0;
          if (!in_data.func) begin
            rx_nxt   = in_data.first_x[W-1:0];
            ry_nxt   = in_data.first_y[W-1:0];
            rinf_nxt = in_data.first_is_infinity;
            cx_nxt   = in_data.second_x[W-1:0];
            cy_nxt   = in_data.second_y[W-1:0];
            cinf_nxt = in_data.second_is_infinity;
          end else begin
            rx_nxt   = '0;
            ry_nxt   = '0;
            rinf_nxt = 1'b1;
            cx_nxt   = in_data.first_x[W-1:0];
            cy_nxt   = in_data.first_y[W-1:0];
            cinf_nxt = in_data.first_is_infinity;
          end
          if (modulus_r[W-1:0] < W'(2)) begin
            rinf_nxt  = 1'b1;
            err_nxt   = 1'b1;
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_RED;
          end
        end
      end

      // Reduce a and the four coordinates modulo p, one division each.
      ST_RED: begin
        alu_use = 1'b1;
        alu_op  = ALU_DIV;
        alu_b   = p_r;
        case (red_cnt_r)
          3'd0:    alu_a = a_r;
          3'd1:    alu_a = rx_r;
          3'd2:    alu_a = ry_r;
          3'd3:    alu_a = cx_r;
          default: alu_a = cy_r;
        endcase
        if (alu_done) begin
          case (red_cnt_r)
            3'd0:    a_nxt  = alu_res2;
            3'd1:    rx_nxt = alu_res2;
            3'd2:    ry_nxt = alu_res2;
            3'd3:    cx_nxt = alu_res2;
            default: cy_nxt = alu_res2;
          endcase
          if (red_cnt_r == RED_LAST) begin
            if (!func_r) begin
              toc_nxt   = 1'b0;
              state_nxt = ST_ADD;
            end else if (k_r == '0 || cinf_r) begin
              state_nxt = ST_OUT;
            end else begin
              state_nxt = ST_LOOP;
            end
          end else begin
            red_cnt_nxt = red_cnt_r + 3'd1;
          end
        end
      end

      ST_LOOP: begin
        if (k_r == '0) begin
          state_nxt = ST_NEG;
        end else begin
          toc_nxt   = ~k_r[0];
          state_nxt = ST_ADD;
        end
      end

      ST_ADD: begin
        if (sinf) begin
          wb_en   = 1'b1;
          wb_x    = cx_r;
          wb_y    = cy_r;
          wb_inf  = cinf_r;
          do_post = 1'b1;
        end else if (cinf_r) begin
          wb_en   = 1'b1;
          wb_x    = sx;
          wb_y    = sy;
          do_post = 1'b1;
        end else if (sx == cx_r && sy != cy_r) begin
          wb_en   = 1'b1;
          wb_inf  = 1'b1;
          do_post = 1'b1;
        end else if (sx == cx_r) begin
          state_nxt = ST_X2;
        end else begin
          state_nxt = ST_CN;
        end
      end

      // Tangent slope numerator 3*x^2 + a and denominator 2*y.
      ST_X2: begin
        alu_use = 1'b1;
        alu_op  = ALU_MUL;
        alu_a   = sx;
        alu_b   = sx;
        if (alu_done) begin
          tmp_nxt   = alu_res;
          state_nxt = ST_N1;
        end
      end

      ST_N1: begin
        alu_use = 1'b1;
        alu_a   = tmp_r;
        alu_b   = tmp_r;
        if (alu_done) begin
          num_nxt   = alu_res;
          state_nxt = ST_N2;
        end
      end

      ST_N2: begin
        alu_use = 1'b1;
        alu_a   = num_r;
        alu_b   = tmp_r;
        if (alu_done) begin
          num_nxt   = alu_res;
          state_nxt = ST_N3;
        end
      end

      ST_N3: begin
        alu_use = 1'b1;
        alu_a   = num_r;
        alu_b   = a_r;
        if (alu_done) begin
          num_nxt   = alu_res;
          state_nxt = ST_DEN;
        end
      end

      ST_DEN: begin
        alu_use = 1'b1;
        alu_a   = sy;
        alu_b   = sy;
        if (alu_done) begin
          if (alu_res == '0) begin
            wb_en   = 1'b1;
            wb_inf  = 1'b1;
            do_post = 1'b1;
          end else begin
            inv_init = 1'b1;
            inv_den  = alu_res;
          end
        end
      end

      // Chord slope numerator and denominator.
      ST_CN: begin
        alu_use = 1'b1;
        alu_op  = ALU_SUB;
        alu_a   = cy_r;
        alu_b   = sy;
        if (alu_done) begin
          num_nxt   = alu_res;
          state_nxt = ST_CD;
        end
      end

      ST_CD: begin
        alu_use = 1'b1;
        alu_op  = ALU_SUB;
        alu_a   = cx_r;
        alu_b   = sx;
        if (alu_done) begin
          inv_init = 1'b1;
          inv_den  = alu_res;
        end
      end

      // Extended Euclid: the inverse exists only if the gcd ends at one.
      ST_INV: begin
        if (r1_r == '0) begin
          if (r0_r == W'(1)) begin
            state_nxt = ST_LAM;
          end else begin
            err_nxt = 1'b1;
            wb_en   = 1'b1;
            wb_inf  = 1'b1;
            do_post = 1'b1;
          end
        end else begin
          state_nxt = ST_DIV;
        end
      end

      ST_DIV: begin
        alu_use = 1'b1;
        alu_op  = ALU_DIV;
        alu_a   = r0_r;
        alu_b   = r1_r;
        if (alu_done) begin
          q_nxt     = (alu_res == p_r) ? '0 : alu_res;
          xr_nxt    = alu_res2;
          state_nxt = ST_QM;
        end
      end

      ST_QM: begin
        alu_use = 1'b1;
        alu_op  = ALU_MUL;
        alu_a   = q_r;
        alu_b   = t1_r;
        if (alu_done) begin
          tmp_nxt   = alu_res;
          state_nxt = ST_NT;
        end
      end

      ST_NT: begin
        alu_use = 1'b1;
        alu_op  = ALU_SUB;
        alu_a   = t0_r;
        alu_b   = tmp_r;
        if (alu_done) begin
          r0_nxt    = r1_r;
          r1_nxt    = xr_r;
          t0_nxt    = t1_r;
          t1_nxt    = alu_res;
          state_nxt = ST_INV;
        end
      end

      ST_LAM: begin
        alu_use = 1'b1;
        alu_op  = ALU_MUL;
        alu_a   = num_r;
        alu_b   = t0_r;
        if (alu_done) begin
          lam_nxt   = alu_res;
          state_nxt = ST_U1;
        end
      end

      ST_U1: begin
        alu_use = 1'b1;
        alu_op  = ALU_MUL;
        alu_a   = lam_r;
        alu_b   = lam_r;
        if (alu_done) begin
          tmp_nxt   = alu_res;
          state_nxt = ST_U2;
        end
      end

      ST_U2: begin
        alu_use = 1'b1;
        alu_op  = ALU_SUB;
        alu_a   = tmp_r;
        alu_b   = sx;
        if (alu_done) begin
          tmp_nxt   = alu_res;
          state_nxt = ST_XR;
        end
      end

      ST_XR: begin
        alu_use = 1'b1;
        alu_op  = ALU_SUB;
        alu_a   = tmp_r;
        alu_b   = cx_r;
        if (alu_done) begin
          xr_nxt    = alu_res;
          state_nxt = ST_V1;
        end
      end

      ST_V1: begin
        alu_use = 1'b1;
        alu_op  = ALU_SUB;
        alu_a   = sx;
        alu_b   = xr_r;
        if (alu_done) begin
          tmp_nxt   = alu_res;
          state_nxt = ST_V2;
        end
      end

      ST_V2: begin
        alu_use = 1'b1;
        alu_op  = ALU_MUL;
        alu_a   = lam_r;
        alu_b   = tmp_r;
        if (alu_done) begin
          tmp_nxt   = alu_res;
          state_nxt = ST_YR;
        end
      end

      ST_YR: begin
        alu_use = 1'b1;
        alu_op  = ALU_SUB;
        alu_a   = tmp_r;
        alu_b   = sy;
        if (alu_done) begin
          wb_en   = 1'b1;
          wb_x    = xr_r;
          wb_y    = alu_res;
          do_post = 1'b1;
        end
      end

      // A negative scalar negates y of a finite result.
      ST_NEG: begin
        if (neg_r && !rinf_r) begin
          alu_use = 1'b1;
          alu_op  = ALU_SUB;
          alu_b   = ry_r;
          if (alu_done) begin
            ry_nxt    = alu_res;
            state_nxt = ST_OUT;
          end
        end else begin
          state_nxt = ST_OUT;
        end
      end

      ST_OUT: state_nxt = ST_IDLE;

      default: state_nxt = ST_IDLE;
    endcase

    if (inv_init) begin
      r0_nxt    = p_r;
      r1_nxt    = inv_den;
      t0_nxt    = '0;
      t1_nxt    = W'(1);
      state_nxt = ST_INV;
    end

    if (wb_en) begin
      if (toc_r) begin
        cx_nxt   = wb_x;
        cy_nxt   = wb_y;
        cinf_nxt = wb_inf;
      end else begin
        rx_nxt   = wb_x;
        ry_nxt   = wb_y;
        rinf_nxt = wb_inf;
      end
    end

    // After a point operation: addition is finished; in a multiplication an
    // accumulate is followed by the doubling, and a doubling ends the bit.
    if (do_post) begin
      if (!func_r) begin
        state_nxt = ST_OUT;
      end else if (!toc_r) begin
        toc_nxt   = 1'b1;
        state_nxt = ST_ADD;
      end else begin
        k_nxt     = k_r >> 1;
        state_nxt = ST_LOOP;
      end
    end

    wait_nxt = wait_r;
    if (alu_use && !wait_r) begin
      wait_nxt = 1'b1;
    end
    if (alu_done) begin
      wait_nxt = 1'b0;
    end
  end

  assign alu_req.go = alu_use && !wait_r;
  assign alu_req.op = alu_op;

  ecp_alu #(
    .W (W)
  ) u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .opa   (alu_a),
    .opb   (alu_b),
    .modp  (p_r),
    .done  (alu_done),
    .res   (alu_res),
    .res2  (alu_res2)
  );

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  always_comb begin
    out_data.result_x           = rinf_r ? 64'd0 : 64'(rx_r);
    out_data.result_y           = rinf_r ? 64'd0 : 64'(ry_r);
    out_data.result_is_infinity = rinf_r;
    out_data.inverse_error      = err_r;
  end

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_done_requested: assert property (@(posedge clk) disable iff (!rst_n)
    alu_done |-> wait_r)
    else $error("arithmetic unit answered without an outstanding request");

  a_inf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.result_is_infinity) |->
      (out_data.result_x == 64'd0 && out_data.result_y == 64'd0))
    else $error("point at infinity carries nonzero coordinates");

  a_euclid_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INV) |-> (t0_r < p_r && t1_r < p_r))
    else $error("inverse coefficients left the field");

endmodule

// ----- rtl/ecp_alu.sv -----
module ecp_alu import ecp_pkg::*; #(
  parameter int W = DEF_FIELD_WIDTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  alu_req_t     req,
  input  logic [W-1:0] opa,
  input  logic [W-1:0] opb,
  input  logic [W-1:0] modp,
  output logic         done,
  output logic [W-1:0] res,
  output logic [W-1:0] res2
);

  localparam int CW = $clog2(W);

  logic          busy_r;
  logic          done_r;
  alu_op_t       op_r;
  logic          ph_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  acc_r, ma_r, mb_r, x_r, res_r, res2_r;

  logic [W-1:0]  mu, mv, madd_res, sub_res, dv_rem;
  logic [W:0]    msum, msum_red, sdiff, dv_t, dv_d;
  logic          dv_q;

  // One modular adder serves both the add operation and the
  // double-and-add steps of the multiplier.
  always_comb begin
    mu       = busy_r ? acc_r : opa;
    mv       = busy_r ? (ph_r ? (mb_r[W-1] ? ma_r : '0) : acc_r) : opb;
    msum     = {1'b0, mu} + {1'b0, mv};
    msum_red = msum - {1'b0, modp};
    madd_res = (msum >= {1'b0, modp}) ? msum_red[W-1:0] : msum[W-1:0];
    sdiff    = {1'b0, opa} - {1'b0, opb};
    sub_res  = sdiff[W] ? (sdiff[W-1:0] + modp) : sdiff[W-1:0];
    dv_t     = {acc_r, x_r[W-1]};
    dv_d     = dv_t - {1'b0, mb_r};
    dv_q     = (dv_t >= {1'b0, mb_r});
    dv_rem   = dv_q ? dv_d[W-1:0] : dv_t[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.go && !busy_r) begin
        op_r  <= req.op;
        acc_r <= '0;
        ma_r  <= opa;
        mb_r  <= opb;
        x_r   <= opa;
        cnt_r <= CW'(W - 1);
        ph_r  <= 1'b0;
        case (req.op)
          ALU_ADD: begin
            res_r  <= madd_res;
            done_r <= 1'b1;
          end
          ALU_SUB: begin
            res_r  <= sub_res;
            done_r <= 1'b1;
          end
          default: busy_r <= 1'b1;
        endcase
      end else if (busy_r) begin
        if (op_r == ALU_MUL) begin
          acc_r <= madd_res;
          ph_r  <= ~ph_r;
          if (ph_r) begin
            mb_r <= mb_r << 1;
            if (cnt_r == '0) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
              res_r  <= madd_res;
            end else begin
              cnt_r <= cnt_r - 1'b1;
            end
          end
        end else begin
          // Restoring division, one quotient bit a cycle.
          acc_r <= dv_rem;
          x_r   <= {x_r[W-2:0], dv_q};
          if (cnt_r == '0) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
            res_r  <= {x_r[W-2:0], dv_q};
            res2_r <= dv_rem;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;
  assign res2 = res2_r;

endmodule
